// ===== sv/nbt_pkg.sv =====
// ----------------------------------------------------------------------------
// nbt_pkg: shared types and constants of the neighbor table
// Entry layout, cell controls, frame codes and result kinds.
// ----------------------------------------------------------------------------
`default_nettype none

package nbt_pkg;

    localparam int MAC_W  = 48;
    localparam int NODE_W = 8;
    localparam int KIND_W = 3;
    localparam int CFG_W  = 2;
    localparam int MODE_W = 2;

    localparam logic [MAC_W-1:0]  BCAST_ADDR = {MAC_W{1'b1}};
    localparam logic [NODE_W-1:0] NO_ROUTE   = 8'd255;

    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [NODE_W-1:0] FT_REQ  = 8'd1;
    localparam logic [NODE_W-1:0] FT_RESP = 8'd2;

    localparam logic [KIND_W-1:0] KIND_HELLO    = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REQUEST  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_RESPONSE = 3'd2;
    localparam logic [KIND_W-1:0] KIND_KNOWN    = 3'd3;
    localparam logic [KIND_W-1:0] KIND_NO_ROUTE = 3'd4;

    localparam logic [CFG_W-1:0] REG_OWN_MAC  = 2'd0;
    localparam logic [CFG_W-1:0] REG_OWN_NODE = 2'd1;

    // What the current item looks up in the table
    localparam logic [MODE_W-1:0] MODE_QUERY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_BCAST = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REQ   = 2'd2;

    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [MAC_W-1:0]  addr;
    } entry_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/nbt_cell.sv =====
// ----------------------------------------------------------------------------
// nbt_cell: one slot of the rotating neighbor ring
// Holds one entry; loads a new entry or takes its neighbor's entry.
// ----------------------------------------------------------------------------
`default_nettype none

module nbt_cell
    import nbt_pkg::*;
(
    input  wire logic      clk,
    input  wire cell_ctl_t ctl,
    input  wire entry_t    load_data,
    input  wire entry_t    shift_in,
    output entry_t         entry
);

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.load)
        begin
            entry_next = load_data;
        end
        else if (ctl.shift)
        begin
            entry_next = shift_in;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

`default_nettype wire

// ===== sv/neighbour_table_route_query_core.sv =====
// ----------------------------------------------------------------------------
// neighbour_table_route_query_core: neighbor table with route queries
// Flow: a lookup turns the ring once in the search state, then the decide state
//   picks the result and the flush state loads it into the output register.
// A fan-out pass turns the ring a second time and holds it while the output stalls.
// The block takes no new item until it is back in idle. A no-route response goes
//   straight to the flush state; an ignored frame leaves the block idle.
// Reset: clears fill count, own MAC/node and control; entries stay unset.
// ----------------------------------------------------------------------------
`default_nettype none

module neighbour_table_route_query_core
    import nbt_pkg::*;
#(
    parameter int TABLE_ENTRIES = 64
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    // configuration write channel
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_W-1:0]  cfg_index,
    input  wire logic [MAC_W-1:0]  cfg_data,

    // input items
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              opcode,
    input  wire logic [MAC_W-1:0]  dest_addr,
    input  wire logic [MAC_W-1:0]  sender_addr,
    input  wire logic [NODE_W-1:0] sender_node,
    input  wire logic [NODE_W-1:0] wanted_node,
    input  wire logic [NODE_W-1:0] answer_node,
    input  wire logic [NODE_W-1:0] frame_type,
    input  wire logic [NODE_W-1:0] query_node,

    // results
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [KIND_W-1:0]      emit_kind,
    output logic [MAC_W-1:0]       target_addr,
    output logic [NODE_W-1:0]      carried_node,
    output logic                   last
);

    localparam int IDXW  = $clog2(TABLE_ENTRIES);
    localparam int FILLW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [IDXW-1:0]  LAST_IDX  = IDXW'(TABLE_ENTRIES - 1);
    localparam logic [FILLW-1:0] FULL_FILL = FILLW'(TABLE_ENTRIES);
    localparam logic [FILLW-1:0] TWO_FILL  = FILLW'(2);

    // Controller states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_DECIDE = 3'd2;
    localparam logic [2:0] S_FANOUT = 3'd3;
    localparam logic [2:0] S_FLUSH  = 3'd4;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    logic [2:0]        state_reg,     state_next;
    logic [MAC_W-1:0]  own_mac_reg,   own_mac_next;
    logic [NODE_W-1:0] own_node_reg,  own_node_next;
    logic [FILLW-1:0]  fill_reg,      fill_next;
    logic [IDXW-1:0]   cnt_reg,       cnt_next;
    logic              hit_reg,       hit_next;
    logic [MODE_W-1:0] mode_reg,      mode_next;
    logic [MAC_W-1:0]  sender_reg,    sender_next;
    logic [NODE_W-1:0] snode_reg,     snode_next;
    logic [NODE_W-1:0] key_reg,       key_next;

    // One result held back so that the final one can be marked last
    logic              pend_valid_reg, pend_valid_next;
    logic [KIND_W-1:0] pend_kind_reg,  pend_kind_next;
    logic [MAC_W-1:0]  pend_addr_reg,  pend_addr_next;
    logic [NODE_W-1:0] pend_node_reg,  pend_node_next;

    // Output register
    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_kind_reg,  out_kind_next;
    logic [MAC_W-1:0]  out_addr_reg,  out_addr_next;
    logic [NODE_W-1:0] out_node_reg,  out_node_next;
    logic              out_last_reg,  out_last_next;

    // ------------------------------------------------------------------------
    // Ring of cells; cell 0 is the head the controller looks at
    // ------------------------------------------------------------------------
    entry_t    ring   [TABLE_ENTRIES];
    cell_ctl_t cell_ctl [TABLE_ENTRIES];
    entry_t    learn_data;
    logic      learn_en;
    logic      ring_shift;
    entry_t    head;

    assign learn_data.node = snode_reg;
    assign learn_data.addr = sender_reg;
    assign head            = ring[0];

    for (genvar g = 0; g < TABLE_ENTRIES; g++)
    begin : g_cell
        assign cell_ctl[g].shift = ring_shift;
        assign cell_ctl[g].load  = learn_en && (fill_reg[IDXW-1:0] == IDXW'(g));

        nbt_cell u_cell
        (
            .clk       (clk),
            .ctl       (cell_ctl[g]),
            .load_data (learn_data),
            .shift_in  (ring[(g + 1) % TABLE_ENTRIES]),
            .entry     (ring[g])
        );
    end

    // ------------------------------------------------------------------------
    // Control
    // ------------------------------------------------------------------------
    logic in_xfer;
    logic out_free;
    logic in_range;
    logic head_match;
    logic fan_cand;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    // Only the filled part of the ring counts during a pass
    assign in_range   = (FILLW'(cnt_reg) < fill_reg);
    assign head_match = (mode_reg == MODE_BCAST) ? (head.addr == sender_reg)
                                                 : (head.node == key_reg);
    assign fan_cand   = in_range && ((mode_reg != MODE_REQ) || (head.addr != sender_reg));

    assign ring_shift = (state_reg == S_SEARCH) || ((state_reg == S_FANOUT) && out_free);

    always_comb
    begin
        state_next      = state_reg;
        own_mac_next    = own_mac_reg;
        own_node_next   = own_node_reg;
        fill_next       = fill_reg;
        cnt_next        = cnt_reg;
        hit_next        = hit_reg;
        mode_next       = mode_reg;
        sender_next     = sender_reg;
        snode_next      = snode_reg;
        key_next        = key_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_addr_next  = pend_addr_reg;
        pend_node_next  = pend_node_reg;
        out_kind_next   = out_kind_reg;
        out_addr_next   = out_addr_reg;
        out_node_next   = out_node_reg;
        out_last_next   = out_last_reg;
        learn_en        = 1'b0;

        // drop the shown result once it is taken
        out_valid_next = out_valid_reg && out_stall;

        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_OWN_MAC:  own_mac_next  = cfg_data;
                REG_OWN_NODE: own_node_next = cfg_data[NODE_W-1:0];
                default:      ;
            endcase
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    sender_next = sender_addr;
                    snode_next  = sender_node;
                    key_next    = (opcode == OP_QUERY) ? query_node : wanted_node;
                    hit_next    = 1'b0;
                    cnt_next    = '0;
                    if (opcode == OP_QUERY)
                    begin
                        mode_next  = MODE_QUERY;
                        state_next = S_SEARCH;
                    end
                    else if (dest_addr == BCAST_ADDR)
                    begin
                        mode_next  = MODE_BCAST;
                        state_next = S_SEARCH;
                    end
                    else if (dest_addr == own_mac_reg)
                    begin
                        if (frame_type == FT_REQ)
                        begin
                            mode_next  = MODE_REQ;
                            state_next = S_SEARCH;
                        end
                        else if ((frame_type == FT_RESP) && (answer_node == NO_ROUTE))
                        begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_NO_ROUTE;
                            pend_addr_next  = sender_addr;
                            pend_node_next  = NO_ROUTE;
                            state_next      = S_FLUSH;
                        end
                    end
                end
            end

            S_SEARCH:
            begin
                // one entry reaches the head each cycle; a full turn brings it home
                if (in_range && head_match)
                begin
                    hit_next = 1'b1;
                end
                cnt_next = cnt_reg + IDXW'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = S_DECIDE;
                end
            end

            S_DECIDE:
            begin
                case (mode_reg)
                    MODE_QUERY:
                    begin
                        if (hit_reg)
                        begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_KNOWN;
                            pend_addr_next  = '0;
                            pend_node_next  = key_reg;
                            state_next      = S_FLUSH;
                        end
                        else if (fill_reg != '0)
                        begin
                            state_next = S_FANOUT;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                    MODE_BCAST:
                    begin
                        if (hit_reg)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            // learn the new neighbor unless the table is full
                            if (fill_reg < FULL_FILL)
                            begin
                                learn_en  = 1'b1;
                                fill_next = fill_reg + FILLW'(1);
                            end
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_HELLO;
                            pend_addr_next  = BCAST_ADDR;
                            pend_node_next  = own_node_reg;
                            state_next      = S_FLUSH;
                        end
                    end
                    default:
                    begin
                        if (hit_reg)
                        begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_RESPONSE;
                            pend_addr_next  = sender_reg;
                            pend_node_next  = own_node_reg;
                            state_next      = S_FLUSH;
                        end
                        else if (fill_reg >= TWO_FILL)
                        begin
                            state_next = S_FANOUT;
                        end
                        else
                        begin
                            pend_valid_next = 1'b1;
                            pend_kind_next  = KIND_RESPONSE;
                            pend_addr_next  = sender_reg;
                            pend_node_next  = NO_ROUTE;
                            state_next      = S_FLUSH;
                        end
                    end
                endcase
            end

            S_FANOUT:
            begin
                // advance only with room at the output; hold the ring otherwise
                if (out_free)
                begin
                    if (fan_cand)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            out_kind_next  = pend_kind_reg;
                            out_addr_next  = pend_addr_reg;
                            out_node_next  = pend_node_reg;
                            out_last_next  = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_kind_next  = KIND_REQUEST;
                        pend_addr_next  = head.addr;
                        pend_node_next  = key_reg;
                    end
                    cnt_next = cnt_reg + IDXW'(1);
                    if (cnt_reg == LAST_IDX)
                    begin
                        cnt_next   = '0;
                        state_next = S_FLUSH;
                    end
                end
            end

            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_kind_next   = pend_kind_reg;
                    out_addr_next   = pend_addr_reg;
                    out_node_next   = pend_node_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            own_mac_reg    <= '0;
            own_node_reg   <= '0;
            fill_reg       <= '0;
            cnt_reg        <= '0;
            hit_reg        <= 1'b0;
            mode_reg       <= MODE_QUERY;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            own_mac_reg    <= own_mac_next;
            own_node_reg   <= own_node_next;
            fill_reg       <= fill_next;
            cnt_reg        <= cnt_next;
            hit_reg        <= hit_next;
            mode_reg       <= mode_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sender_reg    <= sender_next;
        snode_reg     <= snode_next;
        key_reg       <= key_next;
        pend_kind_reg <= pend_kind_next;
        pend_addr_reg <= pend_addr_next;
        pend_node_reg <= pend_node_next;
        out_kind_reg  <= out_kind_next;
        out_addr_reg  <= out_addr_next;
        out_node_reg  <= out_node_next;
        out_last_reg  <= out_last_next;
    end

    assign out_valid    = out_valid_reg;
    assign emit_kind    = out_kind_reg;
    assign target_addr  = out_addr_reg;
    assign carried_node = out_node_reg;
    assign last         = out_last_reg;

endmodule

`default_nettype wire

// ===== bench/neighbour_table_route_query_core_test.sv =====
// ----------------------------------------------------------------------------
// neighbour_table_route_query_core_test: self-checking bench of the neighbor table
// A scripted run of frame headers, local queries and register writes,
// followed by weighted random traffic under several node settings. Every
// item transfer updates a local copy of the table that works out the frames
// to expect, or takes a scripted row's outcome; every result is checked.
// ----------------------------------------------------------------------------

module neighbour_table_route_query_core_test;

    import nbt_pkg::*;

    localparam int NBT_DEPTH       = 64;
    localparam int SETTLE_CYCLES   = 2 * NBT_DEPTH + 8;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int ROUNDS          = 4;
    localparam int ROUND_ITEMS     = 100;

    // frame types that the block must ignore
    localparam logic [NODE_W-1:0] FT_OTHER_LO = 8'd0;
    localparam logic [NODE_W-1:0] FT_OTHER_HI = 8'd255;

    typedef struct packed {
        logic              op;
        logic [MAC_W-1:0]  dest;
        logic [MAC_W-1:0]  snd;
        logic [NODE_W-1:0] snode;
        logic [NODE_W-1:0] wanted;
        logic [NODE_W-1:0] answer;
        logic [NODE_W-1:0] ftype;
        logic [NODE_W-1:0] qnode;
    } frame_item_t;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [MAC_W-1:0]  addr;
        logic [NODE_W-1:0] node;
        logic              fin;
    } emit_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        frame_item_t       it;
        logic [CFG_W-1:0]  reg_idx;
        logic [MAC_W-1:0]  reg_data;
        logic              typed;
        logic              one_emit;
        emit_t             emit;
    } script_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_valid;
    logic              cfg_ready;
    logic [CFG_W-1:0]  cfg_index;
    logic [MAC_W-1:0]  cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic              opcode;
    logic [MAC_W-1:0]  dest_addr;
    logic [MAC_W-1:0]  sender_addr;
    logic [NODE_W-1:0] sender_node;
    logic [NODE_W-1:0] wanted_node;
    logic [NODE_W-1:0] answer_node;
    logic [NODE_W-1:0] frame_type;
    logic [NODE_W-1:0] query_node;
    logic              out_valid;
    logic              out_stall;
    logic [KIND_W-1:0] emit_kind;
    logic [MAC_W-1:0]  target_addr;
    logic [NODE_W-1:0] carried_node;
    logic              last;

    // Local copy of the neighbor table and the two registers
    logic [NODE_W-1:0] nb_node [NBT_DEPTH];
    logic [MAC_W-1:0]  nb_addr [NBT_DEPTH];
    int                nb_count;
    logic [MAC_W-1:0]  my_mac;
    logic [NODE_W-1:0] my_node;

    emit_t pending_emits[$];
    emit_t fresh_emits[$];

    // Scripted rows may carry a hand-written outcome instead of the prediction
    logic  row_typed;
    logic  row_one;
    emit_t row_emit;

    int mismatch_count;
    int idle_cycles;
    int send_calm;
    bit squeeze_req;

    neighbour_table_route_query_core #(
        .TABLE_ENTRIES(NBT_DEPTH)
    ) DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .opcode      (opcode),
        .dest_addr   (dest_addr),
        .sender_addr (sender_addr),
        .sender_node (sender_node),
        .wanted_node (wanted_node),
        .answer_node (answer_node),
        .frame_type  (frame_type),
        .query_node  (query_node),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .emit_kind   (emit_kind),
        .target_addr (target_addr),
        .carried_node(carried_node),
        .last        (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Table model
    // ------------------------------------------------------------------

    function automatic logic addr_listed(input logic [MAC_W-1:0] a);
        for (int k = 0; k < nb_count; k++)
            if (nb_addr[k] == a)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic node_listed(input logic [NODE_W-1:0] n);
        for (int k = 0; k < nb_count; k++)
            if (nb_node[k] == n)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic void push_emit(input logic [KIND_W-1:0] kind,
                                      input logic [MAC_W-1:0] addr,
                                      input logic [NODE_W-1:0] node);
        emit_t e;
        e.kind = kind;
        e.addr = addr;
        e.node = node;
        e.fin  = 1'b0;
        fresh_emits.push_back(e);
    endfunction

    // Work out the frames one item causes and update the table as the block does
    function automatic void compute_emits(input frame_item_t it);
        emit_t e;
        if (it.op == OP_QUERY)
        begin
            if (node_listed(it.qnode))
                push_emit(KIND_KNOWN, '0, it.qnode);
            else
                for (int k = 0; k < nb_count; k++)
                    push_emit(KIND_REQUEST, nb_addr[k], it.qnode);
        end
        else if (it.dest == BCAST_ADDR)
        begin
            // broadcast wins even when our own MAC is all ones
            if (!addr_listed(it.snd))
            begin
                if (nb_count < NBT_DEPTH)
                begin
                    nb_node[nb_count] = it.snode;
                    nb_addr[nb_count] = it.snd;
                    nb_count++;
                end
                push_emit(KIND_HELLO, BCAST_ADDR, my_node);
            end
        end
        else if (it.dest == my_mac)
        begin
            if (it.ftype == FT_REQ)
            begin
                if (node_listed(it.wanted))
                    push_emit(KIND_RESPONSE, it.snd, my_node);
                else if (nb_count >= 2)
                begin
                    // fan out to every neighbor except the one that asked
                    for (int k = 0; k < nb_count; k++)
                        if (nb_addr[k] != it.snd)
                            push_emit(KIND_REQUEST, nb_addr[k], it.wanted);
                end
                else
                    push_emit(KIND_RESPONSE, it.snd, NO_ROUTE);
            end
            else if (it.ftype == FT_RESP && it.answer == NO_ROUTE)
                push_emit(KIND_NO_ROUTE, it.snd, NO_ROUTE);
        end
        if (fresh_emits.size() > 0)
        begin
            e = fresh_emits.pop_back();
            e.fin = 1'b1;
            fresh_emits.push_back(e);
        end
    endfunction

    // ------------------------------------------------------------------
    // Monitor: sample every transfer at the rising edge
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin : watch_transfers
        emit_t       want;
        frame_item_t seen;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (pending_emits.size() == 0)
                begin
                    $error("unexpected result: kind %0d addr %h node %0d last %0d",
                           emit_kind, target_addr, carried_node, last);
                    mismatch_count++;
                end
                else
                begin
                    want = pending_emits.pop_front();
                    if (emit_kind !== want.kind)
                    begin
                        $error("emit_kind: expected %0d, actual %0d", want.kind, emit_kind);
                        mismatch_count++;
                    end
                    if (target_addr !== want.addr)
                    begin
                        $error("target_addr: expected %h, actual %h", want.addr, target_addr);
                        mismatch_count++;
                    end
                    if (carried_node !== want.node)
                    begin
                        $error("carried_node: expected %0d, actual %0d",
                               want.node, carried_node);
                        mismatch_count++;
                    end
                    if (last !== want.fin)
                    begin
                        $error("last: expected %0d, actual %0d", want.fin, last);
                        mismatch_count++;
                    end
                end
            end

            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_OWN_MAC)
                    my_mac = cfg_data;
                else if (cfg_index == REG_OWN_NODE)
                    my_node = cfg_data[NODE_W-1:0];
            end

            if (in_valid && !in_stall)
            begin
                seen.op     = opcode;
                seen.dest   = dest_addr;
                seen.snd    = sender_addr;
                seen.snode  = sender_node;
                seen.wanted = wanted_node;
                seen.answer = answer_node;
                seen.ftype  = frame_type;
                seen.qnode  = query_node;
                compute_emits(seen);
                if (row_typed)
                begin
                    // keep the table update, take the hand-written outcome
                    fresh_emits.delete();
                    if (row_one)
                        pending_emits.push_back(row_emit);
                end
                else
                begin
                    while (fresh_emits.size() > 0)
                        pending_emits.push_back(fresh_emits.pop_front());
                end
            end
        end
    end

    // End the run when nothing has moved for too long
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("neighbour_table_route_query_core_test NOT OK");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    function automatic logic [MAC_W-1:0] rand_mac();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[MAC_W-1:0];
    endfunction

    function automatic logic [NODE_W-1:0] rand_byte();
        logic [31:0] w;
        w = $urandom;
        return w[NODE_W-1:0];
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 95)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Weighted traffic: learning broadcasts, requests and responses to us,
    // local queries, and the rest noise
    function automatic frame_item_t random_item();
        frame_item_t it;
        int          pick;
        it.op     = OP_FRAME;
        it.dest   = rand_mac();
        it.snd    = rand_mac();
        it.snode  = rand_byte();
        it.wanted = rand_byte();
        it.answer = rand_byte();
        it.ftype  = rand_byte();
        it.qnode  = rand_byte();
        pick = $urandom_range(0, 99);
        if (pick < 32)
        begin
            it.dest = BCAST_ADDR;
            if (nb_count > 0 && $urandom_range(0, 3) == 0)
                it.snd = nb_addr[$urandom_range(0, nb_count - 1)];
        end
        else if (pick < 60)
        begin
            it.dest  = my_mac;
            it.ftype = FT_REQ;
            if (nb_count > 0 && $urandom_range(0, 1) == 0)
                it.snd = nb_addr[$urandom_range(0, nb_count - 1)];
            if (nb_count > 0 && $urandom_range(0, 2) == 0)
                it.wanted = nb_node[$urandom_range(0, nb_count - 1)];
        end
        else if (pick < 70)
        begin
            it.dest  = my_mac;
            it.ftype = FT_RESP;
            if ($urandom_range(0, 1) == 0)
                it.answer = NO_ROUTE;
        end
        else if (pick < 86)
        begin
            it.op = OP_QUERY;
            if (nb_count > 0 && $urandom_range(0, 1) == 0)
                it.qnode = nb_node[$urandom_range(0, nb_count - 1)];
        end
        else if ($urandom_range(0, 1) == 0)
            it.dest = my_mac;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Script rows
    // ------------------------------------------------------------------

    function automatic script_row_t item_row(input logic op,
                                             input logic [MAC_W-1:0] dest,
                                             input logic [MAC_W-1:0] snd,
                                             input logic [NODE_W-1:0] snode,
                                             input logic [NODE_W-1:0] wanted,
                                             input logic [NODE_W-1:0] answer,
                                             input logic [NODE_W-1:0] ftype,
                                             input logic [NODE_W-1:0] qnode);
        script_row_t r;
        r           = '0;
        r.kind      = ROW_ITEM;
        r.it.op     = op;
        r.it.dest   = dest;
        r.it.snd    = snd;
        r.it.snode  = snode;
        r.it.wanted = wanted;
        r.it.answer = answer;
        r.it.ftype  = ftype;
        r.it.qnode  = qnode;
        return r;
    endfunction

    function automatic script_row_t reg_row(input logic [CFG_W-1:0] idx,
                                            input logic [MAC_W-1:0] data);
        script_row_t r;
        r          = '0;
        r.kind     = ROW_REG;
        r.reg_idx  = idx;
        r.reg_data = data;
        return r;
    endfunction

    function automatic script_row_t no_emit(input script_row_t r);
        script_row_t t;
        t          = r;
        t.typed    = 1'b1;
        t.one_emit = 1'b0;
        return t;
    endfunction

    function automatic script_row_t one_emit(input script_row_t r,
                                             input logic [KIND_W-1:0] kind,
                                             input logic [MAC_W-1:0] addr,
                                             input logic [NODE_W-1:0] node);
        script_row_t t;
        t           = r;
        t.typed     = 1'b1;
        t.one_emit  = 1'b1;
        t.emit.kind = kind;
        t.emit.addr = addr;
        t.emit.node = node;
        t.emit.fin  = 1'b1;
        return t;
    endfunction

    // ------------------------------------------------------------------
    // Drivers: change inputs at the falling edge
    // ------------------------------------------------------------------

    // Offer one item, hold it until its transfer, return at the next falling edge
    task automatic offer_item(input frame_item_t it);
        int gap;
        if (send_calm > 0)
        begin
            send_calm--;
            gap = 0;
        end
        else
        begin
            gap = idle_len();
            if ($urandom_range(0, 29) == 0)
                send_calm = $urandom_range(15, 40);
        end
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        opcode      = it.op;
        dest_addr   = it.dest;
        sender_addr = it.snd;
        sender_node = it.snode;
        wanted_node = it.wanted;
        answer_node = it.answer;
        frame_type  = it.ftype;
        query_node  = it.qnode;
        in_valid    = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drop the item valid, drain every expected result, then let the block go quiet
    task automatic settle();
        in_valid = 1'b0;
        while (pending_emits.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_W-1:0] idx, input logic [MAC_W-1:0] data);
        @(negedge clk);
        cfg_index = idx;
        cfg_data  = data;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Result side: random stall runs, calm stretches, and one long hold-off on request
    initial
    begin : drain_side
        int stall_left;
        int free_left;
        stall_left = 0;
        free_left  = 0;
        out_stall  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (squeeze_req)
            begin
                // hold off long enough for the block to back up onto its input
                squeeze_req = 1'b0;
                out_stall   = 1'b1;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                out_stall   = 1'b0;
            end
            else if (stall_left > 0)
            begin
                out_stall = 1'b1;
                stall_left--;
            end
            else if (free_left > 0)
            begin
                out_stall = 1'b0;
                free_left--;
            end
            else
            begin
                stall_left = idle_len();
                free_left  = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 80)
                                                          : $urandom_range(0, 6);
                out_stall  = 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        script_row_t       script[$];
        script_row_t       row;
        logic [MAC_W-1:0]  round_mac;
        logic [NODE_W-1:0] round_node;

        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        in_valid    = 1'b0;
        opcode      = OP_FRAME;
        dest_addr   = '0;
        sender_addr = '0;
        sender_node = '0;
        wanted_node = '0;
        answer_node = '0;
        frame_type  = '0;
        query_node  = '0;
        row_typed   = 1'b0;
        row_one     = 1'b0;
        row_emit    = '0;
        nb_count    = 0;
        my_mac      = '0;
        my_node     = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        send_calm   = 0;
        squeeze_req = 1'b0;

        // Registers at reset: own MAC zero, own node zero, empty table
        script.push_back(no_emit(item_row(OP_QUERY, '0, '0, '0, '0, '0, '0, 8'd0)));
        script.push_back(one_emit(item_row(OP_FRAME, '0, 48'h0000_0000_0001, 8'd3, 8'd0,
                                           8'd0, FT_REQ, 8'hFF),
                                  KIND_RESPONSE, 48'h0000_0000_0001, NO_ROUTE));
        script.push_back(one_emit(item_row(OP_FRAME, '0, 48'hFFFF_FFFF_FFFE, 8'd0, 8'd0,
                                           NO_ROUTE, FT_RESP, 8'd0),
                                  KIND_NO_ROUTE, 48'hFFFF_FFFF_FFFE, NO_ROUTE));
        script.push_back(no_emit(item_row(OP_FRAME, '0, 48'h0000_0000_0002, 8'd0, 8'd0,
                                          8'd254, FT_RESP, 8'd0)));
        script.push_back(no_emit(item_row(OP_FRAME, '0, 48'h0000_0000_0003, 8'd0, 8'd0,
                                          8'd0, FT_OTHER_LO, 8'd0)));
        script.push_back(no_emit(item_row(OP_FRAME, '0, 48'h0000_0000_0004, 8'd0, 8'd0,
                                          8'd0, FT_OTHER_HI, 8'd0)));
        script.push_back(no_emit(item_row(OP_FRAME, 48'h1234_5678_9ABC, 48'h0000_0000_0005,
                                          8'd0, 8'd0, 8'd0, FT_REQ, 8'd0)));
        // Own MAC equal to broadcast: the broadcast path must still win
        script.push_back(reg_row(REG_OWN_MAC, BCAST_ADDR));
        script.push_back(reg_row(REG_OWN_NODE, {{(MAC_W-NODE_W){1'b0}}, NO_ROUTE}));
        script.push_back(one_emit(item_row(OP_FRAME, BCAST_ADDR, '0, 8'd0, 8'd0, 8'd0,
                                           FT_REQ, 8'd0),
                                  KIND_HELLO, BCAST_ADDR, NO_ROUTE));
        script.push_back(no_emit(item_row(OP_FRAME, BCAST_ADDR, '0, 8'd77, 8'd0, 8'd0,
                                          FT_REQ, 8'd0)));
        script.push_back(reg_row(REG_OWN_MAC, '0));
        script.push_back(reg_row(REG_OWN_NODE, '0));
        script.push_back(one_emit(item_row(OP_FRAME, BCAST_ADDR, BCAST_ADDR, 8'hFF, 8'd0,
                                           8'd0, FT_OTHER_LO, 8'd0),
                                  KIND_HELLO, BCAST_ADDR, 8'd0));
        // Query hit ignores every other field
        script.push_back(one_emit(item_row(OP_QUERY, 48'h0F0F_0F0F_0F0F, 48'h0000_0000_0009,
                                           8'd1, 8'd2, 8'd3, FT_REQ, 8'hFF),
                                  KIND_KNOWN, '0, 8'hFF));
        // Query miss fans out to both neighbors
        script.push_back(item_row(OP_QUERY, '0, '0, '0, '0, '0, '0, 8'd5));
        script.push_back(one_emit(item_row(OP_FRAME, '0, '0, 8'd0, 8'hFF, 8'd0, FT_REQ,
                                           8'd0),
                                  KIND_RESPONSE, '0, 8'd0));
        // Request misses with two neighbors: fan out, skipping the asker
        script.push_back(item_row(OP_FRAME, '0, BCAST_ADDR, 8'd0, 8'd9, 8'd0, FT_REQ, 8'd0));
        script.push_back(item_row(OP_FRAME, '0, 48'hAAAA_AAAA_AAAA, 8'd0, 8'd9, 8'd0,
                                  FT_REQ, 8'd0));
        script.push_back(one_emit(item_row(OP_FRAME, BCAST_ADDR, 48'h5555_5555_5555, 8'hAA,
                                           8'd0, 8'd0, FT_RESP, 8'd0),
                                  KIND_HELLO, BCAST_ADDR, 8'd0));
        script.push_back(one_emit(item_row(OP_FRAME, '0, 48'h0123_4567_89AB, 8'd0, 8'd0,
                                           NO_ROUTE, FT_RESP, 8'hFF),
                                  KIND_NO_ROUTE, 48'h0123_4567_89AB, NO_ROUTE));
        script.push_back(one_emit(item_row(OP_QUERY, BCAST_ADDR, BCAST_ADDR, 8'hFF, 8'hFF,
                                           8'hFF, 8'hFF, 8'hAA),
                                  KIND_KNOWN, '0, 8'hAA));

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Walk the script
        for (int k = 0; k < script.size(); k++)
        begin
            row = script[k];
            if (row.kind == ROW_REG)
            begin
                settle();
                write_reg(row.reg_idx, row.reg_data);
            end
            else
            begin
                row_typed = row.typed;
                row_one   = row.one_emit;
                row_emit  = row.emit;
                offer_item(row.it);
            end
        end
        row_typed = 1'b0;

        // Random rounds, each under its own node setting
        for (int rnd = 0; rnd < ROUNDS; rnd++)
        begin
            case (rnd)
                1:
                begin
                    round_mac  = BCAST_ADDR;
                    round_node = NO_ROUTE;
                end
                3:
                begin
                    round_mac  = '0;
                    round_node = '0;
                end
                default:
                begin
                    round_mac  = rand_mac();
                    round_node = rand_byte();
                end
            endcase
            settle();
            write_reg(REG_OWN_MAC, round_mac);
            write_reg(REG_OWN_NODE, {{(MAC_W-NODE_W){1'b0}}, round_node});
            // back the block up while items keep coming
            if (rnd == 2)
                squeeze_req = 1'b1;
            for (int k = 0; k < ROUND_ITEMS; k++)
                offer_item(random_item());
        end

        settle();
        if (mismatch_count == 0)
            $display("neighbour_table_route_query_core_test OK");
        else
            $display("neighbour_table_route_query_core_test NOT OK");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/nbt_pkg.sv
sv/nbt_cell.sv
sv/neighbour_table_route_query_core.sv
bench/neighbour_table_route_query_core_test.sv
